### sv/assert_macros.svh
// assertion macros for the nearest waypoint block
// no dependencies; the checks drop out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define NWL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define NWL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define NWL_ASSERT(label, clk, rst_n, prop, msg)
`define NWL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/nwl_pkg.sv
// shared types, codes and constants of the nearest waypoint block
// no dependencies
`default_nettype none
package nwl_pkg;
	localparam int COORD_W   = 24;
	localparam int LOOK_W    = 16;
	localparam int THR_W     = 16;
	localparam int IDX_OUT_W = 10;
	localparam int DIST_W    = 24;
	localparam int SQ_W      = 50;
	localparam int ROOT_W    = SQ_W / 2;
	localparam int PT_W      = 2 * COORD_W;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int WALK_LIMIT_DEF = 4096;
	localparam logic [THR_W-1:0] THR_RESET = 16'd400;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_QUERY = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FEW   = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]                mode;
		logic signed [COORD_W-1:0] pos_x_mm;
		logic signed [COORD_W-1:0] pos_y_mm;
		logic [LOOK_W-1:0]         lookahead_mm;
	} cmd_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [IDX_OUT_W-1:0] nearest_index;
		logic [IDX_OUT_W-1:0] window_end;
		logic [DIST_W-1:0]    nearest_dist_mm;
		logic                 full_search;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_WALK,
		ST_WRD0,
		ST_WRD1,
		ST_WDIST,
		ST_WDWAIT,
		ST_WSQRT,
		ST_FIN,
		ST_FWAIT
	} state_t;
endpackage
`default_nettype wire

### sv/nearest_waypoint_lookahead_window_top.sv
// nearest waypoint search with lookahead window, top level and sequencer
// depends on nwl_pkg, nwl_ram, nwl_dist, nwl_isqrt, assert_macros.svh
//
// channel  direction  handshake            payload
// cmd      in         start & !busy        cmd   (nwl_pkg::cmd_t)
// rsp      out        done, one cycle      rsp   (nwl_pkg::rsp_t)
// cfg      in         cfg_valid&cfg_ready  cfg_data (threshold)
//
// load, clear and queries on fewer than two points answer in the cycle after
// the transfer. during the search a query reads one waypoint per cycle from
// the table ram, over the window, then the whole table when the window hit
// is too far; each walk step takes two reads, the distance pipe and the
// square root, and a final square root gives the distance.
// busy holds off new commands until the response; the receiver cannot stall.
// reset clears count and window and sets the threshold to 400; the table needs no clearing.
`default_nettype none
`include "assert_macros.svh"
module nearest_waypoint_lookahead_window_top #(
	parameter int MAX_POINTS = nwl_pkg::MAX_POINTS_DEF,
	parameter int WALK_LIMIT = nwl_pkg::WALK_LIMIT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire nwl_pkg::cmd_t               cmd,
	output logic                             done,
	output nwl_pkg::rsp_t                    rsp,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [nwl_pkg::THR_W-1:0]   cfg_data
);
	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int STEP_W = $clog2(WALK_LIMIT + 1);
	localparam int SQ_W   = nwl_pkg::SQ_W;
	localparam int CW     = nwl_pkg::COORD_W;
	localparam int LW     = nwl_pkg::LOOK_W;

	nwl_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q;
	logic              first_q;
	logic [IDX_W-1:0]  last_start_q, last_end_q;
	logic [nwl_pkg::THR_W-1:0] thr_q;
	logic [2*nwl_pkg::THR_W-1:0] thr_sq_q;
	logic signed [CW-1:0] px_q, py_q, ax_q, ay_q;
	logic [LW-1:0]     look_q, total_q;
	logic              full_q;
	logic [IDX_W-1:0]  issue_idx_q, cmp_idx_q, found_q, end_q, nx_q;
	logic [CNT_W-1:0]  issue_left_q, out_left_q, win_len;
	logic [SQ_W-1:0]   best_q, sel_best;
	logic [IDX_W-1:0]  sel_found;
	logic [STEP_W-1:0] steps_q;
	logic              rd_vld_s1;

	logic accept, acc_query, acc_load, full_tbl;
	nwl_pkg::rsp_t acc_rsp;
	logic ram_we, ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [nwl_pkg::PT_W-1:0] ram_rdata;
	logic signed [CW-1:0] rd_x, rd_y;

	logic dist_vld, dist_out_vld;
	logic signed [CW-1:0] d_ax, d_ay, d_bx, d_by;
	logic [SQ_W-1:0] dist_sq;

	logic sqrt_start, sqrt_busy, sqrt_done;
	logic [SQ_W-1:0] sqrt_val;
	logic [nwl_pkg::ROOT_W-1:0] root;
	logic [nwl_pkg::ROOT_W:0] walk_sum;
	logic search_last, go_full;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i,
			input logic [CNT_W-1:0] n);
		logic [IDX_W-1:0] r;
		if (CNT_W'(i) == n - CNT_W'(1)) begin
			r = '0;
		end else begin
			r = i + IDX_W'(1);
		end
		return r;
	endfunction

	assign busy      = state_q != nwl_pkg::ST_IDLE;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign full_tbl  = cnt_q == CNT_W'(MAX_POINTS);
	assign acc_load  = accept && cmd.mode == nwl_pkg::MODE_LOAD;
	assign acc_query = accept && cmd.mode == nwl_pkg::MODE_QUERY;
	assign ram_we    = acc_load && !full_tbl;

	assign rd_x = $signed(ram_rdata[nwl_pkg::PT_W-1:CW]);
	assign rd_y = $signed(ram_rdata[CW-1:0]);

	assign win_len = (last_end_q >= last_start_q)
		? CNT_W'(last_end_q) - CNT_W'(last_start_q) + CNT_W'(1)
		: CNT_W'(last_end_q) + cnt_q - CNT_W'(last_start_q) + CNT_W'(1);

	assign sel_best  = (dist_sq < best_q) ? dist_sq : best_q;
	assign sel_found = (dist_sq < best_q) ? cmp_idx_q : found_q;
	assign search_last = state_q == nwl_pkg::ST_SEARCH && dist_out_vld
		&& out_left_q == CNT_W'(1);
	assign go_full  = !full_q && sel_best > SQ_W'(thr_sq_q);
	assign walk_sum = (nwl_pkg::ROOT_W+1)'(total_q) + (nwl_pkg::ROOT_W+1)'(root);

	nwl_ram #(.WIDTH(nwl_pkg::PT_W), .DEPTH(MAX_POINTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata ({cmd.pos_x_mm, cmd.pos_y_mm}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	nwl_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (dist_vld),
		.ax     (d_ax),
		.ay     (d_ay),
		.bx     (d_bx),
		.by     (d_by),
		.sq_vld (dist_out_vld),
		.sq     (dist_sq)
	);

	nwl_isqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.val    (sqrt_val),
		.busy   (sqrt_busy),
		.done   (sqrt_done),
		.root   (root)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nwl_pkg::ST_IDLE: begin
				if (acc_query && cnt_q >= CNT_W'(2)) begin
					state_d = nwl_pkg::ST_SEARCH;
				end
			end
			nwl_pkg::ST_SEARCH: begin
				if (search_last && !go_full) begin
					state_d = nwl_pkg::ST_WALK;
				end
			end
			nwl_pkg::ST_WALK: begin
				if (total_q < look_q && steps_q < STEP_W'(WALK_LIMIT)) begin
					state_d = nwl_pkg::ST_WRD0;
				end else begin
					state_d = nwl_pkg::ST_FIN;
				end
			end
			nwl_pkg::ST_WRD0:  state_d = nwl_pkg::ST_WRD1;
			nwl_pkg::ST_WRD1:  state_d = nwl_pkg::ST_WDIST;
			nwl_pkg::ST_WDIST: state_d = nwl_pkg::ST_WDWAIT;
			nwl_pkg::ST_WDWAIT: begin
				if (dist_out_vld) begin
					state_d = nwl_pkg::ST_WSQRT;
				end
			end
			nwl_pkg::ST_WSQRT: begin
				if (sqrt_done) begin
					state_d = (walk_sum < (nwl_pkg::ROOT_W+1)'(look_q))
						? nwl_pkg::ST_WALK : nwl_pkg::ST_FIN;
				end
			end
			nwl_pkg::ST_FIN:   state_d = nwl_pkg::ST_FWAIT;
			nwl_pkg::ST_FWAIT: begin
				if (sqrt_done) begin
					state_d = nwl_pkg::ST_IDLE;
				end
			end
			default: state_d = nwl_pkg::ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		ram_re     = 1'b0;
		ram_raddr  = issue_idx_q;
		dist_vld   = 1'b0;
		d_ax       = ax_q;
		d_ay       = ay_q;
		d_bx       = rd_x;
		d_by       = rd_y;
		sqrt_start = 1'b0;
		sqrt_val   = dist_sq;
		unique case (state_q)
			nwl_pkg::ST_SEARCH: begin
				ram_re   = issue_left_q != '0;
				dist_vld = rd_vld_s1;
				d_ax     = rd_x;
				d_ay     = rd_y;
				d_bx     = px_q;
				d_by     = py_q;
			end
			nwl_pkg::ST_WRD0: begin
				ram_re    = 1'b1;
				ram_raddr = end_q;
			end
			nwl_pkg::ST_WRD1: begin
				ram_re    = 1'b1;
				ram_raddr = nx_q;
			end
			nwl_pkg::ST_WDIST:  dist_vld = 1'b1;
			nwl_pkg::ST_WDWAIT: sqrt_start = dist_out_vld;
			nwl_pkg::ST_FIN: begin
				sqrt_start = 1'b1;
				sqrt_val   = best_q;
			end
			default: begin
			end
		endcase
	end

	// immediate response of the transfer
	always_comb begin
		acc_rsp = '0;
		unique case (cmd.mode)
			nwl_pkg::MODE_LOAD:
				acc_rsp.status = full_tbl ? nwl_pkg::STAT_FULL : nwl_pkg::STAT_OK;
			nwl_pkg::MODE_QUERY:
				acc_rsp.status = (cnt_q < CNT_W'(2)) ? nwl_pkg::STAT_FEW : nwl_pkg::STAT_OK;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= nwl_pkg::ST_IDLE;
			cnt_q        <= '0;
			first_q      <= 1'b1;
			last_start_q <= '0;
			last_end_q   <= '0;
			thr_q        <= nwl_pkg::THR_RESET;
			done         <= 1'b0;
			rd_vld_s1    <= 1'b0;
			issue_left_q <= '0;
		end else begin
			state_q   <= state_d;
			done      <= (accept && !(acc_query && cnt_q >= CNT_W'(2)))
				|| (state_q == nwl_pkg::ST_FWAIT && sqrt_done);
			rd_vld_s1 <= state_q == nwl_pkg::ST_SEARCH && ram_re;
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			if (accept) begin
				unique case (cmd.mode)
					nwl_pkg::MODE_LOAD: begin
						if (!full_tbl) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					nwl_pkg::MODE_CLEAR: begin
						cnt_q        <= '0;
						first_q      <= 1'b1;
						last_start_q <= '0;
						last_end_q   <= '0;
					end
					nwl_pkg::MODE_QUERY: begin
						if (cnt_q >= CNT_W'(2)) begin
							if (first_q) begin
								first_q      <= 1'b0;
								issue_left_q <= cnt_q;
							end else begin
								issue_left_q <= win_len;
							end
						end
					end
					default: begin
					end
				endcase
			end
			if (state_q == nwl_pkg::ST_SEARCH) begin
				if (search_last && go_full) begin
					issue_left_q <= cnt_q;
				end else if (ram_re) begin
					issue_left_q <= issue_left_q - CNT_W'(1);
				end
			end
			if (state_q == nwl_pkg::ST_FWAIT && sqrt_done) begin
				last_start_q <= found_q;
				last_end_q   <= end_q;
			end
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp <= acc_rsp;
		end
		if (acc_query) begin
			px_q     <= cmd.pos_x_mm;
			py_q     <= cmd.pos_y_mm;
			look_q   <= cmd.lookahead_mm;
			thr_sq_q <= (2*nwl_pkg::THR_W)'(thr_q) * (2*nwl_pkg::THR_W)'(thr_q);
			best_q   <= '1;
			full_q   <= first_q;
			if (first_q) begin
				issue_idx_q <= '0;
				cmp_idx_q   <= '0;
				found_q     <= '0;
				out_left_q  <= cnt_q;
			end else begin
				issue_idx_q <= last_start_q;
				cmp_idx_q   <= last_start_q;
				found_q     <= last_start_q;
				out_left_q  <= win_len;
			end
		end
		if (state_q == nwl_pkg::ST_SEARCH) begin
			if (search_last && go_full) begin
				// window hit too far: rescan the whole table
				full_q      <= 1'b1;
				best_q      <= '1;
				found_q     <= '0;
				cmp_idx_q   <= '0;
				issue_idx_q <= '0;
				out_left_q  <= cnt_q;
			end else begin
				if (ram_re) begin
					issue_idx_q <= wrap_inc(issue_idx_q, cnt_q);
				end
				if (dist_out_vld) begin
					best_q     <= sel_best;
					found_q    <= sel_found;
					cmp_idx_q  <= wrap_inc(cmp_idx_q, cnt_q);
					out_left_q <= out_left_q - CNT_W'(1);
				end
				if (search_last) begin
					end_q   <= sel_found;
					total_q <= '0;
					steps_q <= '0;
				end
			end
		end
		if (state_q == nwl_pkg::ST_WALK) begin
			nx_q <= wrap_inc(end_q, cnt_q);
		end
		if (state_q == nwl_pkg::ST_WRD1) begin
			ax_q <= rd_x;
			ay_q <= rd_y;
		end
		if (state_q == nwl_pkg::ST_WSQRT && sqrt_done
				&& walk_sum < (nwl_pkg::ROOT_W+1)'(look_q)) begin
			total_q <= LW'(walk_sum);
			end_q   <= nx_q;
			steps_q <= steps_q + STEP_W'(1);
		end
		if (state_q == nwl_pkg::ST_FWAIT && sqrt_done) begin
			rsp.status          <= nwl_pkg::STAT_OK;
			rsp.nearest_index   <= nwl_pkg::IDX_OUT_W'(found_q);
			rsp.window_end      <= nwl_pkg::IDX_OUT_W'(end_q);
			rsp.nearest_dist_mm <= root[nwl_pkg::ROOT_W-1]
				? '1 : root[nwl_pkg::DIST_W-1:0];
			rsp.full_search     <= full_q;
		end
	end

	`NWL_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= CNT_W'(MAX_POINTS), "point count overflow")
	`NWL_ASSERT_NEXT(a_query_ack, clk, arst_n, acc_query, busy || done, "query not taken up")
	`NWL_ASSERT(a_cmp_idx, clk, arst_n, !(state_q == nwl_pkg::ST_SEARCH && dist_out_vld) || CNT_W'(cmp_idx_q) < cnt_q, "search index beyond table")
	`NWL_ASSERT(a_sqrt_free, clk, arst_n, !(sqrt_start && sqrt_busy), "square root restarted while busy")
endmodule
`default_nettype wire

### sv/nwl_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none
module nwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### sv/nwl_dist.sv
// squared euclidean distance, three register stages
// depends on nwl_pkg
`default_nettype none
module nwl_dist (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 vld,
	input  wire logic signed [nwl_pkg::COORD_W-1:0]   ax,
	input  wire logic signed [nwl_pkg::COORD_W-1:0]   ay,
	input  wire logic signed [nwl_pkg::COORD_W-1:0]   bx,
	input  wire logic signed [nwl_pkg::COORD_W-1:0]   by,
	output logic                                      sq_vld,
	output logic             [nwl_pkg::SQ_W-1:0]      sq
);
	localparam int DW = nwl_pkg::COORD_W + 1;

	logic signed [DW-1:0] dx, dy;
	logic [DW-1:0] adx_s1, ady_s1;
	logic [2*DW-1:0] prodx, prody;
	logic [nwl_pkg::SQ_W-1:0] sqx_s2, sqy_s2;
	logic vld_s1, vld_s2;

	assign dx = DW'(ax) - DW'(bx);
	assign dy = DW'(ay) - DW'(by);
	assign prodx = adx_s1 * adx_s1;
	assign prody = ady_s1 * ady_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			sq_vld <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			sq_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		adx_s1 <= dx[DW-1] ? DW'(-dx) : DW'(dx);
		ady_s1 <= dy[DW-1] ? DW'(-dy) : DW'(dy);
		sqx_s2 <= nwl_pkg::SQ_W'(prodx);
		sqy_s2 <= nwl_pkg::SQ_W'(prody);
		sq     <= sqx_s2 + sqy_s2;
	end
endmodule
`default_nettype wire

### sv/nwl_isqrt.sv
// iterative floor square root, one result bit per cycle
// depends on nwl_pkg
`default_nettype none
module nwl_isqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [nwl_pkg::SQ_W-1:0]      val,
	output logic                               busy,
	output logic                               done,
	output logic      [nwl_pkg::ROOT_W-1:0]    root
);
	localparam int SQ_W = nwl_pkg::SQ_W;
	localparam int IT_W = $clog2(nwl_pkg::ROOT_W + 1);

	logic [SQ_W-1:0] v_q, res_q, bit_q, trial;
	logic [IT_W-1:0] left_q;

	assign trial = res_q + bit_q;
	assign busy  = left_q != '0;
	assign root  = res_q[nwl_pkg::ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= !start && left_q == IT_W'(1);
			if (start) begin
				left_q <= IT_W'(nwl_pkg::ROOT_W);
			end else if (busy) begin
				left_q <= left_q - IT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= val;
			res_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule
`default_nettype wire
